[sv/plst_pkg.sv]
// Package for the positional list store: item structs, operation, status
// and cell control codes shared by the cell row and the top level.
// No dependencies.
`default_nettype none

package plst_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 6;
  localparam int LEN_W        = 6;

  localparam logic [2:0] OP_INSERT_AT  = 3'd0;
  localparam logic [2:0] OP_DELETE_AT  = 3'd1;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd4;
  localparam logic [2:0] OP_POP_BACK   = 3'd5;
  localparam logic [2:0] OP_MERGE_ITEM = 3'd6;
  localparam logic [2:0] OP_DUMP       = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // Control codes for what every cell of the row does.
  localparam logic [1:0] CM_HOLD = 2'd0;
  localparam logic [1:0] CM_INS  = 2'd1;
  localparam logic [1:0] CM_DEL  = 2'd2;
  localparam logic [1:0] CM_ROT  = 2'd3;

  typedef struct packed {
    logic [2:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
    logic                    merge_first;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [LEN_W-1:0]        list_length;
    logic signed [VAL_W-1:0] element_value;
    logic                    element_valid;
    logic                    last_result;
  } res_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/positional_list_store_core.sv]
// Positional list store: a command item is accepted into a hold register, then runs in an
// execute step that shifts the cell row; no new item is accepted until the held one is done.
// A dump of N elements emits N results, one per cycle when not stalled, as the row rotates.
// The result register loads in the execute step, once the output is free.
// Synchronous reset clears the count, merge cursor, busy flag and result valid; the cell
// contents are not cleared, and only entries below the count are ever read.
`default_nettype none

module positional_list_store_core #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  plst_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output plst_pkg::res_t res
);
  import plst_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Control state.
  logic          busy;
  cmd_t          hold;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] cursor;
  logic [CW-1:0] cursor_next;
  logic [CW-1:0] dump_idx;

  // The cell row.
  cell_ctl_t               ctl;
  logic [CW-1:0]           pos_eff;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     less;

  // Execute handshake: the held item runs when the result register can take a result.
  logic    out_free;
  logic    exec;
  logic    accept;
  logic    done;
  res_t    res_next;
  logic    full;
  logic    empty;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;

  // Merge search.
  logic [CW-1:0]       cur_eff;
  logic [CAPACITY-1:0] stop;
  logic [CW-1:0]       ins_pos;

  assign cmd_stall = busy;
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign exec      = busy && out_free;

  assign full  = (count >= CAP_C);
  assign empty = (count == '0);
  assign pos_x = CMPW'(hold.position);
  assign cnt_x = CMPW'(count);

  // Cells at or past the clamped cursor stop the search when they are past the end of
  // the list or hold a value not below the merge value. The lowest such cell wins.
  always_comb begin
    if (hold.merge_first) begin
      cur_eff = '0;
    end else if (cursor > count) begin
      cur_eff = count;
    end else begin
      cur_eff = cursor;
    end
  end

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      stop[j] = (CW'(j) >= cur_eff) && ((CW'(j) >= count) || !less[j]);
    end
  end

  always_comb begin
    ins_pos = count;
    for (int j = CAPACITY - 1; j >= 0; j--) begin
      if (stop[j]) begin
        ins_pos = CW'(j);
      end
    end
  end

  // Decode of the held item into a row operation, new count and result.
  always_comb begin
    logic [1:0] mode;
    logic [1:0] st;
    mode        = CM_HOLD;
    st          = ST_OK;
    pos_eff     = '0;
    count_next  = count;
    cursor_next = cursor;
    done        = 1'b1;
    res_next    = '0;

    unique case (hold.operation)
      OP_INSERT_AT: begin
        if (full) begin
          st = ST_FULL;
        end else if (pos_x > cnt_x) begin
          st = ST_BADPOS;
        end else begin
          mode    = CM_INS;
          pos_eff = CW'(hold.position);
        end
      end
      OP_DELETE_AT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st = ST_BADPOS;
        end else begin
          mode    = CM_DEL;
          pos_eff = CW'(hold.position);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          mode = CM_INS;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          mode = CM_DEL;
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          mode    = CM_INS;
          pos_eff = count;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          mode    = CM_DEL;
          pos_eff = count - 1'b1;
        end
      end
      OP_MERGE_ITEM: begin
        if (full) begin
          st          = ST_FULL;
          cursor_next = hold.merge_first ? '0 : cursor;
        end else begin
          mode        = CM_INS;
          pos_eff     = ins_pos;
          cursor_next = ins_pos + 1'b1;
        end
      end
      OP_DUMP: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          // Cell zero is shown while the row rotates by one; after count rotations
          // the list is back in its original order.
          mode = CM_ROT;
          done = ({1'b0, dump_idx} + 1'b1 == {1'b0, count});
          res_next.element_value = cell_val[0];
          res_next.element_valid = 1'b1;
        end
      end
      default: st = ST_OK;
    endcase

    if (mode == CM_INS) begin
      count_next = count + 1'b1;
    end else if (mode == CM_DEL) begin
      count_next = count - 1'b1;
    end

    res_next.status      = st;
    res_next.list_length = LEN_W'(count_next);
    res_next.last_result = done;

    ctl.mode  = exec ? mode : CM_HOLD;
    ctl.value = hold.item_value;
  end

  // Row of cells; the ends take their own value from the missing neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = cell_val[g];
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    plst_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (pos_eff),
      .cnt       (count),
      .left_val  (left_v),
      .right_val (right_v),
      .wrap_val  (cell_val[0]),
      .val       (cell_val[g]),
      .less      (less[g])
    );
  end

  // Held item register.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= cmd;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (exec) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      cursor    <= '0;
      dump_idx  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy     <= 1'b1;
        dump_idx <= '0;
      end else if (exec) begin
        busy     <= !done;
        dump_idx <= dump_idx + 1'b1;
      end
      if (exec) begin
        count  <= count_next;
        cursor <= cursor_next;
      end
      if (exec) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // The list never grows past its capacity.
  a_count_cap : assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("list count above capacity");

  // The merge cursor never points beyond one past the last cell.
  a_cursor_cap : assert property (@(posedge clk) disable iff (rst)
    cursor <= CAP_C)
    else $error("merge cursor above capacity");

  // Every item other than a dump leaves the core idle once it has executed.
  a_single_exec : assert property (@(posedge clk) disable iff (rst)
    exec && (hold.operation != OP_DUMP) |=> !busy)
    else $error("non-dump item still busy after execute");

  // A fresh result only appears after an execute cycle.
  a_res_source : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(exec))
    else $error("result valid without execute");

  // During a dump the element index stays inside the list.
  a_dump_range : assert property (@(posedge clk) disable iff (rst)
    busy && (hold.operation == OP_DUMP) && (count != '0) |-> dump_idx < count)
    else $error("dump index past end of list");

endmodule

`default_nettype wire

[sv/plst_cell.sv]
// One cell of the list row: holds one entry and loads it from itself, the
// broadcast value, a neighbor or cell zero. Depends on plst_pkg.
`default_nettype none

module plst_cell #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF,
  parameter int INDEX    = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  plst_pkg::cell_ctl_t               ctl,
  input  logic [CW-1:0]                     pos,
  input  logic [CW-1:0]                     cnt,
  input  logic signed [plst_pkg::VAL_W-1:0] left_val,
  input  logic signed [plst_pkg::VAL_W-1:0] right_val,
  input  logic signed [plst_pkg::VAL_W-1:0] wrap_val,
  output logic signed [plst_pkg::VAL_W-1:0] val,
  output logic                              less
);
  import plst_pkg::*;

  localparam logic [CW-1:0] IDX  = CW'(INDEX);
  localparam logic [CW:0]   IDX1 = (CW + 1)'(INDEX + 1);

  logic signed [VAL_W-1:0] val_next;

  always_comb begin
    val_next = val;
    unique case (ctl.mode)
      CM_HOLD: val_next = val;
      CM_INS: begin
        if (IDX == pos) begin
          val_next = ctl.value;
        end else if (IDX > pos) begin
          val_next = left_val;
        end
      end
      CM_DEL: begin
        if (IDX >= pos) begin
          val_next = right_val;
        end
      end
      CM_ROT: begin
        if (IDX1 < {1'b0, cnt}) begin
          val_next = right_val;
        end else if (IDX1 == {1'b0, cnt}) begin
          val_next = wrap_val;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

  assign less = (val < ctl.value);

endmodule

`default_nettype wire
